// File: rtl/core/sbus_frame_decoder_core_defines.svh
// Assertion macros shared by the sbus frame decoder core.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SBUS_FRAME_DECODER_CORE_DEFINES_SVH
`define SBUS_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfd assertion failed in %m");

// Next-cycle implication, disabled during reset.
`define SFD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfd assertion failed in %m");

`endif

// File: rtl/core/sfd_pkg.sv
// Package for the sbus frame decoder core: frame constants and the
// structs passed between the unpacker and the drain. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 11;
  localparam int NUM_CH     = 16;
  localparam int CH_IDX_W   = 4;
  localparam int FLAG_W     = 4;
  localparam int POS_W      = 5;
  localparam int DATA_BYTES = 22;
  localparam int FLAGS_POS  = 22;
  localparam int END_POS    = 23;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h0F;

  // channel store write port
  typedef struct packed {
    logic                we;
    logic [CH_IDX_W-1:0] addr;
    logic [CHAN_W-1:0]   data;
  } sfd_wr_t;

  // frame completion notice from unpacker to drain
  typedef struct packed {
    logic              start;
    logic [FLAG_W-1:0] flags;
  } sfd_frame_t;

endpackage

// File: rtl/core/sfd_if.sv
// Valid/ready channel interfaces of the sbus frame decoder core.
// Depends on sfd_pkg for field widths.
`timescale 1ns / 1ps

interface sfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [sfd_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfd_pkg::CH_IDX_W-1:0]  channel_index;
  logic [sfd_pkg::CHAN_W-1:0]    channel_value;
  logic                          digital_ch17;
  logic                          digital_ch18;
  logic                          frame_lost;
  logic                          failsafe;
  logic                          last;

  modport source (output valid, output channel_index, output channel_value,
                  output digital_ch17, output digital_ch18, output frame_lost,
                  output failsafe, output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input digital_ch17, input digital_ch18, input frame_lost,
                  input failsafe, input last, output ready);
endinterface

// File: rtl/core/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/sfd_unpack.sv
// Frame sync and bit-serial channel unpacker: hunts for the start byte,
// shifts data bytes one bit per cycle into 11-bit channel words.
// Depends on sfd_pkg, sfd_if and the assertion macro header.
`timescale 1ns / 1ps
`include "sbus_frame_decoder_core_defines.svh"

module sfd_unpack (
  input  logic                clk,
  input  logic                rst_n,
  sfd_in_if.sink              in_ch,
  input  logic                drain_busy,
  output sfd_pkg::sfd_wr_t    wr,
  output sfd_pkg::sfd_frame_t frame
);

  typedef enum logic [2:0] {
    S_HUNT  = 3'b001,
    S_RECV  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  logic [sfd_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [sfd_pkg::BYTE_W-1:0]       byte_sr_r, byte_sr_nxt;
  logic [2:0]                       bit_cnt_r, bit_cnt_nxt;
  logic [sfd_pkg::CHAN_W-1:0]       chan_sr_r, chan_sr_nxt;
  logic [3:0]                       chan_bits_r, chan_bits_nxt;
  logic [sfd_pkg::CH_IDX_W-1:0]     chan_idx_r, chan_idx_nxt;
  logic [sfd_pkg::FLAG_W-1:0]       flags_r, flags_nxt;
  logic [sfd_pkg::CHAN_W-1:0]       shift_in;
  logic                             accept;
  logic                             wr_en;
  logic                             start_pulse;

  assign in_ch.ready = ((state_r == S_HUNT) || (state_r == S_RECV)) && !drain_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // LSB-first: next frame bit enters at the channel word's MSB
  assign shift_in = {byte_sr_r[0], chan_sr_r[sfd_pkg::CHAN_W-1:1]};

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    byte_sr_nxt   = byte_sr_r;
    bit_cnt_nxt   = bit_cnt_r;
    chan_sr_nxt   = chan_sr_r;
    chan_bits_nxt = chan_bits_r;
    chan_idx_nxt  = chan_idx_r;
    flags_nxt     = flags_r;
    wr_en         = 1'b0;
    start_pulse   = 1'b0;
    unique case (state_r)
      S_HUNT: begin
        if (accept && (in_ch.rx_byte == sfd_pkg::SYNC_BYTE)) begin
          state_nxt     = S_RECV;
          pos_nxt       = '0;
          chan_bits_nxt = '0;
          chan_idx_nxt  = '0;
        end
      end
      S_RECV: begin
        if (accept) begin
          if (pos_r < sfd_pkg::POS_W'(sfd_pkg::DATA_BYTES)) begin
            byte_sr_nxt = in_ch.rx_byte;
            bit_cnt_nxt = '0;
            pos_nxt     = pos_r + 1'b1;
            state_nxt   = S_SHIFT;
          end else if (pos_r == sfd_pkg::POS_W'(sfd_pkg::FLAGS_POS)) begin
            flags_nxt = in_ch.rx_byte[sfd_pkg::BYTE_W-1 -: sfd_pkg::FLAG_W];
            pos_nxt   = pos_r + 1'b1;
          end else begin
            // end byte: value ignored, frame complete
            start_pulse = 1'b1;
            state_nxt   = S_HUNT;
          end
        end
      end
      S_SHIFT: begin
        chan_sr_nxt = shift_in;
        byte_sr_nxt = byte_sr_r >> 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (chan_bits_r == 4'(sfd_pkg::CHAN_W - 1)) begin
          wr_en         = 1'b1;
          chan_bits_nxt = '0;
          chan_idx_nxt  = chan_idx_r + 1'b1;
        end else begin
          chan_bits_nxt = chan_bits_r + 1'b1;
        end
        if (bit_cnt_r == 3'd7) begin
          state_nxt = S_RECV;
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HUNT;
      pos_r       <= '0;
      bit_cnt_r   <= '0;
      chan_bits_r <= '0;
      chan_idx_r  <= '0;
      flags_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      chan_bits_r <= chan_bits_nxt;
      chan_idx_r  <= chan_idx_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_sr_r <= byte_sr_nxt;
    chan_sr_r <= chan_sr_nxt;
  end

  assign wr.we       = wr_en;
  assign wr.addr     = chan_idx_r;
  assign wr.data     = shift_in;
  assign frame.start = start_pulse;
  assign frame.flags = flags_r;

  // 22 bytes hold exactly 16 channels: the end byte finds the packer empty
  `SFD_ASSERT_IMP(a_frame_aligned,
                  accept && (state_r == S_RECV) &&
                  (pos_r == sfd_pkg::POS_W'(sfd_pkg::END_POS)),
                  (chan_idx_r == 4'd0) && (chan_bits_r == 4'd0))
  // store is never written while the previous frame is still being read
  `SFD_ASSERT_IMP(a_no_write_during_drain, wr_en, !drain_busy)

endmodule

// File: rtl/core/sfd_drain.sv
// Channel store and result drain: reads the sixteen stored channels one
// per cycle unless the output stalls; the store's read register is the
// output register. Depends on sfd_pkg, sfd_if, sfd_ram, assertion macros.
`timescale 1ns / 1ps
`include "sbus_frame_decoder_core_defines.svh"

module sfd_drain (
  input  logic                clk,
  input  logic                rst_n,
  input  sfd_pkg::sfd_wr_t    wr,
  input  sfd_pkg::sfd_frame_t frame,
  output logic                busy,
  sfd_out_if.source           out_ch
);

  logic                          busy_r;
  logic [sfd_pkg::CH_IDX_W-1:0]  rd_cnt_r;
  logic                          valid_r;
  logic [sfd_pkg::CH_IDX_W-1:0]  idx_r;
  logic                          last_r;
  logic [sfd_pkg::FLAG_W-1:0]    frame_flags_r;
  logic [sfd_pkg::FLAG_W-1:0]    out_flags_r;
  logic [sfd_pkg::CHAN_W-1:0]    rd_data;
  logic                          issue;
  logic                          final_rd;

  // read the next channel when the output slot is empty or being taken
  assign issue    = busy_r && (!valid_r || out_ch.ready);
  assign final_rd = (rd_cnt_r == sfd_pkg::CH_IDX_W'(sfd_pkg::NUM_CH - 1));

  sfd_ram #(
    .WIDTH (sfd_pkg::CHAN_W),
    .DEPTH (sfd_pkg::NUM_CH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr.we),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (issue),
    .rd_addr (rd_cnt_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_cnt_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (frame.start) begin
        busy_r   <= 1'b1;
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
        if (final_rd) begin
          busy_r <= 1'b0;
        end
      end
      if (issue) begin
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.start) begin
      frame_flags_r <= frame.flags;
    end
    if (issue) begin
      idx_r       <= rd_cnt_r;
      last_r      <= final_rd;
      out_flags_r <= frame_flags_r;
    end
  end

  assign busy                 = busy_r;
  assign out_ch.valid         = valid_r;
  assign out_ch.channel_index = idx_r;
  assign out_ch.channel_value = rd_data;
  assign out_ch.digital_ch17  = out_flags_r[3];
  assign out_ch.digital_ch18  = out_flags_r[2];
  assign out_ch.frame_lost    = out_flags_r[1];
  assign out_ch.failsafe      = out_flags_r[0];
  assign out_ch.last          = last_r;

  `SFD_ASSERT_IMP(a_start_when_idle, frame.start, !busy_r)
  `SFD_ASSERT_IMP(a_index_in_order, issue && valid_r, rd_cnt_r == idx_r + 4'd1)
  // the final read of a frame releases the input
  `SFD_ASSERT_NXT(a_last_ends_drain, issue && final_rd, !busy_r)

endmodule

// File: rtl/core/sbus_frame_decoder_core.sv
// SBUS frame decoder top level: receives one serial byte per input item and
// emits sixteen channel results per complete frame. The byte stream is
// synchronized on the start byte 0x0F; the following 22 data bytes are
// unpacked bit-serially, one bit per clock, into sixteen 11-bit channels
// (LSB first), byte 23 supplies the four flags (ch17, ch18, frame lost,
// failsafe) and byte 24 closes the frame without any check. While hunting,
// bytes other than the start byte are dropped; inside a frame a start byte
// is simply data. A data byte is accepted and then shifted through the
// bit-serial packer before the next byte is taken; hunting, flags and end
// bytes are handled on acceptance. The end byte starts a drain of the
// 16-entry channel store, one result per cycle when the consumer is ready,
// last set on channel 15; the store's single read port sets that rate. New
// bytes are held off until all sixteen reads have been issued, so the final
// result may still sit in the output register while the next frame begins.
// Depends on sfd_pkg, sfd_if, sfd_ram, sfd_unpack and sfd_drain.
`timescale 1ns / 1ps

module sbus_frame_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  sfd_in_if.sink     in_ch,
  sfd_out_if.source  out_ch
);

  // channel store write port, unpacker to drain
  sfd_pkg::sfd_wr_t    wr;
  // end-of-frame notice carrying the latched flags
  sfd_pkg::sfd_frame_t frame;
  // drain still has channels to read: input is held off
  logic                drain_busy;

  sfd_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .drain_busy (drain_busy),
    .wr         (wr),
    .frame      (frame)
  );

  sfd_drain u_drain (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .frame  (frame),
    .busy   (drain_busy),
    .out_ch (out_ch)
  );

endmodule
